/* sv/mbd_pkg.sv */
// Shared types and constants for the motion burst decoder.
// No dependencies; imported by motion_burst_decoder_unit.
package mbd_pkg;

  localparam int HistLen = 8;

  localparam logic [7:0] MotBit   = 8'h80;
  localparam logic [7:0] LiftBit  = 8'h08;
  localparam logic [7:0] FwRunBit = 8'h80;

  localparam int FeatureShift = 3;
  localparam int RawMulShift  = 10;
  localparam int RawDiv       = 1296;

  // floor(n / RawDiv) as (n * RawRecip) >> RawRecipShift, exact for n < 2^18
  localparam int RawRecipShift = 30;
  localparam int RawRecip      = ((2 ** RawRecipShift) + RawDiv - 1) / RawDiv;
  localparam int RawRecipW     = $clog2(RawRecip + 1);
  localparam int RawNumW       = 8 + RawMulShift;
  localparam int RawProdW      = RawNumW + RawRecipW;

  typedef struct packed {
    logic [7:0] motion_byte;
    logic [7:0] observation_byte;
    logic [7:0] dx_low;
    logic [7:0] dx_high;
    logic [7:0] dy_low;
    logic [7:0] dy_high;
    logic [7:0] surface_quality;
    logic [7:0] raw_sum;
    logic [7:0] shutter_high;
    logic [7:0] shutter_low;
  } mbd_in_t;

  typedef struct packed {
    logic               moved;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic               lift_now;
    logic               lift_filtered;
    logic [1:0]         operating_mode;
    logic               firmware_running;
    logic [10:0]        feature_count;
    logic [7:0]         raw_average;
    logic [15:0]        shutter_value;
  } mbd_out_t;

endpackage

/* sv/motion_burst_decoder_unit.sv */
// Motion burst decoder: input register, single-pass decode, result register.
// Depends on mbd_pkg for the transaction types and constants.
//
// One burst transaction per cycle while the result is not stalled: a burst is
// held in the input register, and the decode together with the position
// accumulators and lift history updates happens as it moves into the result
// register. The result register and input register form a two-deep pipe;
// in_stall_o rises only when both are full and the result is stalled. X and Y
// positions wrap modulo 2^32; the lift flag changes only when the last HistLen
// lift bits all agree.
module motion_burst_decoder_unit import mbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mbd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mbd_out_t out_data_o
);

  logic                in_valid_q;
  mbd_in_t             in_q;
  logic                out_valid_q;
  mbd_out_t            out_q, out_d;
  logic signed [31:0]  pos_x_q, pos_x_d;
  logic signed [31:0]  pos_y_q, pos_y_d;
  logic [HistLen-1:0]  hist_q, hist_d;
  logic                lift_q, lift_d;

  logic                out_ready;
  logic                adv;
  logic                in_take;
  logic                moved;
  logic                lift;
  logic signed [15:0]  dx, dy;
  logic [RawNumW-1:0]  raw_num;
  logic [RawProdW-1:0] raw_prod;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    moved = |(in_q.motion_byte & MotBit);
    lift  = |(in_q.motion_byte & LiftBit);
    dx    = moved ? $signed({in_q.dx_high, in_q.dx_low}) : 16'sd0;
    dy    = moved ? $signed({in_q.dy_high, in_q.dy_low}) : 16'sd0;

    pos_x_d = pos_x_q - 32'(dx);
    pos_y_d = pos_y_q - 32'(dy);

    hist_d = {hist_q[HistLen-2:0], lift};
    lift_d = lift_q;
    if (hist_d == '0) begin
      lift_d = 1'b0;
    end else if (hist_d == '1) begin
      lift_d = 1'b1;
    end

    raw_num  = {in_q.raw_sum, {RawMulShift{1'b0}}};
    raw_prod = RawProdW'(raw_num) * RawProdW'(RawRecip);

    out_d.moved            = moved;
    out_d.delta_x          = dx;
    out_d.delta_y          = dy;
    out_d.position_x       = pos_x_d;
    out_d.position_y       = pos_y_d;
    out_d.lift_now         = lift;
    out_d.lift_filtered    = lift_d;
    out_d.operating_mode   = in_q.motion_byte[2:1];
    out_d.firmware_running = |(in_q.observation_byte & FwRunBit);
    out_d.feature_count    = {in_q.surface_quality, {FeatureShift{1'b0}}};
    out_d.raw_average      = raw_prod[RawRecipShift +: 8];
    out_d.shutter_value    = {in_q.shutter_high, in_q.shutter_low};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      hist_q      <= '0;
      lift_q      <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        hist_q      <= hist_d;
        lift_q      <= lift_d;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled while pipeline not full");

  a_no_motion_zero_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.moved) |->
      (out_data_o.delta_x == 16'sd0 && out_data_o.delta_y == 16'sd0))
    else $error("nonzero delta without motion");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !moved) |=> (pos_x_q == $past(pos_x_q) && pos_y_q == $past(pos_y_q)))
    else $error("position changed without motion");

  a_lift_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(lift_q) |-> (hist_q == '1))
    else $error("lift flag rose with mixed history");
`endif

endmodule

/* bench/testbench.sv */
// Testbench for motion_burst_decoder_unit: directed table and random bursts,
// checked in order against a local burst decoder model or, for typed rows, fixed values.
// Depends on mbd_pkg for the transaction types and constants.
`timescale 1ns / 100ps

module testbench;
  import mbd_pkg::*;

  typedef struct {
    mbd_in_t  burst;
    bit       typed;
    mbd_out_t want;
  } burst_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  mbd_in_t  in_burst = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mbd_out_t out_report;

  logic signed [31:0] acc_x = '0;
  logic signed [31:0] acc_y = '0;
  logic [HistLen-1:0] lift_hist = '0;
  logic               lift_deb = 1'b0;

  mbd_out_t   decoded_q[$];
  burst_row_t dir_rows[$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         hold_armed = 1'b0;

  motion_burst_decoder_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_burst),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_report)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic mbd_out_t decode_burst(input mbd_in_t b);
    mbd_out_t r;
    logic     lift;
    r.moved          = (b.motion_byte & MotBit) != '0;
    r.delta_x        = r.moved ? {b.dx_high, b.dx_low} : '0;
    r.delta_y        = r.moved ? {b.dy_high, b.dy_low} : '0;
    acc_x            = acc_x - $signed(r.delta_x);
    acc_y            = acc_y - $signed(r.delta_y);
    lift             = (b.motion_byte & LiftBit) != '0;
    lift_hist        = {lift_hist[HistLen-2:0], lift};
    if (lift_hist == '0) begin
      lift_deb = 1'b0;
    end else if (&lift_hist) begin
      lift_deb = 1'b1;
    end
    r.position_x       = acc_x;
    r.position_y       = acc_y;
    r.lift_now         = lift;
    r.lift_filtered    = lift_deb;
    r.operating_mode   = b.motion_byte[2:1];
    r.firmware_running = (b.observation_byte & FwRunBit) != '0;
    r.feature_count    = 11'(b.surface_quality) << FeatureShift;
    r.raw_average      = 8'((int'(b.raw_sum) << RawMulShift) / RawDiv);
    r.shutter_value    = {b.shutter_high, b.shutter_low};
    return r;
  endfunction

  function automatic mbd_out_t mk_out(input bit mv, input int dx, input int dy,
                                      input int px, input int py, input bit ln,
                                      input bit lf, input int mode, input bit fw,
                                      input int feat, input int avg, input int shut);
    mbd_out_t r;
    r.moved            = mv;
    r.delta_x          = 16'(dx);
    r.delta_y          = 16'(dy);
    r.position_x       = 32'(px);
    r.position_y       = 32'(py);
    r.lift_now         = ln;
    r.lift_filtered    = lf;
    r.operating_mode   = 2'(mode);
    r.firmware_running = fw;
    r.feature_count    = 11'(feat);
    r.raw_average      = 8'(avg);
    r.shutter_value    = 16'(shut);
    return r;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic add_row(input mbd_in_t b, input bit typed, input mbd_out_t want);
    burst_row_t row;
    row.burst = b;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_burst(input mbd_in_t b, input bit typed, input mbd_out_t want);
    int       gap;
    mbd_out_t pred;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_burst <= b;
    do @(posedge clk); while (in_stall);
    pred = decode_burst(b);
    decoded_q.push_back(typed ? want : pred);
  endtask

  task automatic check_report(input mbd_out_t got);
    mbd_out_t want;
    string    bad;
    if (decoded_q.size() == 0) begin
      if (mismatches < 10) $display("unexpected transaction: %p", got);
      mismatches++;
      return;
    end
    want = decoded_q.pop_front();
    bad = "";
    if (got.moved !== want.moved) bad = {bad, " moved"};
    if (got.delta_x !== want.delta_x) bad = {bad, " delta_x"};
    if (got.delta_y !== want.delta_y) bad = {bad, " delta_y"};
    if (got.position_x !== want.position_x) bad = {bad, " position_x"};
    if (got.position_y !== want.position_y) bad = {bad, " position_y"};
    if (got.lift_now !== want.lift_now) bad = {bad, " lift_now"};
    if (got.lift_filtered !== want.lift_filtered) bad = {bad, " lift_filtered"};
    if (got.operating_mode !== want.operating_mode) bad = {bad, " operating_mode"};
    if (got.firmware_running !== want.firmware_running) bad = {bad, " firmware_running"};
    if (got.feature_count !== want.feature_count) bad = {bad, " feature_count"};
    if (got.raw_average !== want.raw_average) bad = {bad, " raw_average"};
    if (got.shutter_value !== want.shutter_value) bad = {bad, " shutter_value"};
    if (bad != "") begin
      if (mismatches < 10) begin
        $display("mismatch in%s\n  expected %p\n  actual   %p", bad, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_report(out_report);
  end

  // receiver: random hold-off per transaction, one long hold once armed
  initial begin : receiver
    int n;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      n = draw_wait();
      if (hold_armed && !held) begin
        held = 1'b1;
        n = 400;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : driver
    mbd_in_t    b;
    mbd_out_t   none;
    logic [15:0] dxv, dyv;
    logic [7:0]  m;
    bit          lift_lvl, lift;
    none = '0;
    lift_lvl = 1'b0;

    add_row(80'h00_00_00_00_00_00_00_00_00_00, 1'b1, '0);
    add_row(80'h80_80_FF_7F_00_80_FF_FF_FF_FF, 1'b1,
            mk_out(1, 32767, -32768, -32767, 32768, 0, 0, 0, 1, 2040, 201, 65535));
    add_row(80'h7F_7F_FF_FF_FF_FF_01_A0_01_00, 1'b1,
            mk_out(0, 0, 0, -32767, 32768, 1, 0, 3, 0, 8, 126, 256));
    add_row(80'h88_00_01_00_FF_FF_55_50_12_34, 1'b0, none);
    add_row(80'h8A_80_00_80_01_00_AA_9F_AB_CD, 1'b0, none);
    add_row(80'h8C_01_FF_FF_00_00_80_00_00_01, 1'b0, none);
    add_row(80'h8E_FE_34_12_78_56_7F_01_80_00, 1'b0, none);
    add_row(80'h0E_80_11_22_33_44_0F_F0_0F_F0, 1'b0, none);
    add_row(80'h88_00_00_00_00_00_F0_0F_F0_0F, 1'b0, none);
    add_row(80'h8B_7F_C0_FF_40_00_C3_3C_5A_A5, 1'b0, none);
    add_row(80'hF1_00_AA_55_55_AA_3C_C3_A5_5A, 1'b0, none);
    add_row(80'h89_FF_01_80_FF_7F_01_A1_00_FF, 1'b0, none);
    add_row(80'h80_00_02_00_FE_FF_02_02_02_02, 1'b0, none);
    add_row(80'h00_80_99_99_99_99_20_40_60_80, 1'b0, none);
    add_row(80'h96_00_10_F0_F0_10_E0_A0_00_00, 1'b0, none);
    add_row(80'h04_FF_00_00_00_00_00_00_00_00, 1'b0, none);
    add_row(80'hC2_40_7F_00_80_FF_40_50_FF_00, 1'b0, none);
    add_row(80'h70_20_0F_0F_F0_F0_10_90_11_11, 1'b0, none);
    add_row(80'h81_08_FF_80_00_7F_08_80_22_22, 1'b0, none);
    add_row(80'h00_00_00_00_00_00_00_00_00_00, 1'b0, none);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_burst(dir_rows[i].burst, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < 550; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == 100) begin
        calm = 1'b0;
        hold_armed = 1'b1;
      end
      b = mbd_in_t'(80'({$urandom, $urandom, $urandom}));
      if ($urandom_range(0, 5) == 0) lift_lvl = ~lift_lvl;
      lift = ($urandom_range(0, 9) == 0) ? 1'($urandom) : lift_lvl;
      m = b.motion_byte & ~(MotBit | LiftBit);
      if ($urandom_range(0, 3) != 0) m = m | MotBit;
      if (lift) m = m | LiftBit;
      b.motion_byte = m;
      dxv = 16'($urandom);
      dyv = 16'($urandom);
      if ($urandom_range(0, 1) != 0) dxv = 16'($urandom_range(0, 31)) - 16'd16;
      if ($urandom_range(0, 1) != 0) dyv = 16'($urandom_range(0, 31)) - 16'd16;
      {b.dx_high, b.dx_low} = dxv;
      {b.dy_high, b.dy_low} = dyv;
      if ($urandom_range(0, 3) != 0) b.raw_sum = 8'($urandom_range(0, 160));
      send_burst(b, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
sv/mbd_pkg.sv
sv/motion_burst_decoder_unit.sv
bench/testbench.sv
